/* design/stwl_pkg.sv */
package stwl_pkg;

    localparam int BUFFER_DEPTH_DEF     = 2048;
    localparam int BUFFER_MIDDLE_DEF    = 1024;
    localparam int WINDOW_WIDTH_DEF     = 250;
    localparam int LEFT_BOUND_DEF       = 125;
    localparam int RIGHT_BOUND_DEF      = 1923;
    localparam int GRID_STEP_POINTS_DEF = 5;

    localparam int SAMPLE_W = 12;
    localparam int PAN_W    = 12;
    localparam int TB_W     = 20;
    localparam int POS_W    = 11;
    localparam int START_W  = 13;
    localparam int TPOS_W   = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    // signed working width for window arithmetic, covers bounds and indexes up to 262143
    localparam int CALC_W = 19;
    // magnitude width of the room before the grid division
    localparam int ROOM_W = 17;

    localparam logic [SAMPLE_W-1:0] LEVEL_RESET = SAMPLE_W'(2048);
    localparam logic [PAN_W-1:0]    PAN_RESET   = '0;
    localparam logic [TB_W-1:0]     TB_RESET    = TB_W'(1000);

    localparam logic [1:0] REG_TRIGGER_LEVEL  = 2'd0;
    localparam logic [1:0] REG_PAN_OFFSET     = 2'd1;
    localparam logic [1:0] REG_TIMEBASE_VALUE = 2'd2;

endpackage

/* design/scope_trigger_window_locator.sv */
// result: once the last sample word is taken, the result passes the stage registers to m_valid
// throughput: one sample word per cycle while s_ready is high; search updates per word
// stages: search registers, window compare and grid divide, time multiply and saturation
// reset: aresetn synchronous active low, clears the search state and the pipeline and
// restores trigger_level 2048, pan_offset 0, timebase_value 1000
module scope_trigger_window_locator
    import stwl_pkg::*;
#(
    parameter int BUFFER_DEPTH     = BUFFER_DEPTH_DEF,
    parameter int BUFFER_MIDDLE    = BUFFER_MIDDLE_DEF,
    parameter int WINDOW_WIDTH     = WINDOW_WIDTH_DEF,
    parameter int LEFT_BOUND       = LEFT_BOUND_DEF,
    parameter int RIGHT_BOUND      = RIGHT_BOUND_DEF,
    parameter int GRID_STEP_POINTS = GRID_STEP_POINTS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_W-1:0]        s_sample,
    input  logic                       s_last,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [POS_W-1:0]           m_trigger_position,
    output logic                       m_trigger_found,
    output logic signed [START_W-1:0]  m_window_start,
    output logic signed [PAN_W-1:0]    m_adjusted_pan,
    output logic signed [TPOS_W-1:0]   m_time_position,
    output logic                       m_pan_clamped
);

    localparam int IW   = $clog2(BUFFER_DEPTH + 1);
    localparam int DMAX = (BUFFER_MIDDLE > BUFFER_DEPTH) ? BUFFER_MIDDLE : BUFFER_DEPTH;
    localparam int DW   = $clog2(DMAX + 1);
    localparam int GL   = $clog2(GRID_STEP_POINTS);

    localparam int    ROOM_SH    = ROOM_W + GL;
    localparam int    ROOM_PW    = ROOM_SH + ROOM_W;
    localparam longint ROOM_RECIP =
        ((longint'(1) << ROOM_SH) + GRID_STEP_POINTS - 1) / GRID_STEP_POINTS;

    localparam int    TB_SH    = TB_W + GL;
    localparam int    TB_PW    = TB_SH + TB_W;
    localparam longint TB_RECIP =
        ((longint'(1) << TB_SH) + GRID_STEP_POINTS - 1) / GRID_STEP_POINTS;

    localparam int TP_W = TB_W + ROOM_W + 1;

    localparam logic [IW-1:0] DEPTH_C = IW'(BUFFER_DEPTH);
    localparam logic [DW-1:0] MID_C   = DW'(BUFFER_MIDDLE);

    localparam logic signed [CALC_W-1:0] LEFT_C  = CALC_W'(LEFT_BOUND);
    localparam logic signed [CALC_W-1:0] RIGHT_C = CALC_W'(RIGHT_BOUND);
    localparam logic signed [CALC_W-1:0] WIDTH_C = CALC_W'(WINDOW_WIDTH);
    localparam logic signed [CALC_W-1:0] GRID_C  = CALC_W'(GRID_STEP_POINTS);
    localparam logic signed [CALC_W-1:0] PAN_MAX = CALC_W'(2047);
    localparam logic signed [CALC_W-1:0] PAN_MIN = -CALC_W'(2048);
    localparam logic signed [CALC_W-1:0] ST_MAX  = CALC_W'(4095);
    localparam logic signed [CALC_W-1:0] ST_MIN  = -CALC_W'(4096);
    localparam logic signed [TP_W-1:0]   TP_MAX  = TP_W'(64'sd2147483647);
    localparam logic signed [TP_W-1:0]   TP_MIN  = -TP_MAX - TP_W'(1);

    // configuration
    logic [SAMPLE_W-1:0]     level_reg;
    logic signed [PAN_W-1:0] pan_reg;
    logic [TB_W-1:0]         tb_reg;
    logic [TB_W-1:0]         unit_reg;
    logic [TB_PW-1:0]        unit_prod;
    logic                    cfg_write;
    logic [1:0]              cfg_index;

    // search state
    logic [SAMPLE_W-1:0] prev_reg;
    logic [IW-1:0]       idx_reg;
    logic [IW-1:0]       best_reg;
    logic [DW-1:0]       dist_reg;
    logic [IW-1:0]       best_next;
    logic [DW-1:0]       dist_next;
    logic [IW-1:0]       cross_idx;
    logic [DW-1:0]       cross_ext;
    logic [DW-1:0]       cross_dist;
    logic                cross_hit;
    logic                idx_full;
    logic                s_accept;

    // pipeline control
    logic p1_valid_reg;
    logic p2_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic p2_move;
    logic p2_free;
    logic p1_move;

    // stage 1
    logic [IW-1:0]              p1_t_reg;
    logic signed [CALC_W-1:0]   t1_s;
    logic signed [CALC_W-1:0]   pan_s;
    logic signed [CALC_W-1:0]   tp_s;
    logic signed [CALC_W-1:0]   room;
    logic signed [CALC_W-1:0]   room_abs;
    logic [ROOM_W-1:0]          room_mag;
    logic [ROOM_PW-1:0]         room_prod;
    logic [ROOM_W-1:0]          quot;
    logic                       p2_clamped_next;
    logic signed [ROOM_W:0]     p2_steps_next;
    logic signed [CALC_W-1:0]   p2_start_next;

    // stage 2
    logic [IW-1:0]              p2_t_reg;
    logic                       p2_clamped_reg;
    logic signed [ROOM_W:0]     p2_steps_reg;
    logic signed [CALC_W-1:0]   p2_start_reg;
    logic signed [CALC_W-1:0]   t2_s;
    logic signed [CALC_W-1:0]   adj_full;
    logic signed [CALC_W-1:0]   adj_sat;
    logic signed [CALC_W-1:0]   start_sel;
    logic signed [CALC_W-1:0]   start_sat;
    logic signed [TP_W-1:0]     tpos_full;
    logic signed [TP_W-1:0]     tpos_sat;
    logic [31:0]                t2_wide;
    logic signed [PAN_W-1:0]    m_adj_next;
    logic signed [TPOS_W-1:0]   m_tpos_next;

    logic [POS_W-1:0]           m_pos_reg;
    logic                       m_found_reg;
    logic signed [START_W-1:0]  m_start_reg;
    logic signed [PAN_W-1:0]    m_adj_reg;
    logic signed [TPOS_W-1:0]   m_tpos_reg;
    logic                       m_clamped_reg;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[ADDR_W-1:2];

    always_comb begin
        case (cfg_index)
            REG_TRIGGER_LEVEL:  prdata = {{(DATA_W-SAMPLE_W){1'b0}}, level_reg};
            REG_PAN_OFFSET:     prdata = {{(DATA_W-PAN_W){1'b0}}, pan_reg};
            REG_TIMEBASE_VALUE: prdata = {{(DATA_W-TB_W){1'b0}}, tb_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_RESET;
            pan_reg   <= PAN_RESET;
            tb_reg    <= TB_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_TRIGGER_LEVEL:  level_reg <= pwdata[SAMPLE_W-1:0];
                REG_PAN_OFFSET:     pan_reg   <= pwdata[PAN_W-1:0];
                REG_TIMEBASE_VALUE: tb_reg    <= pwdata[TB_W-1:0];
                default: ;
            endcase
        end
    end

    // timebase units per grid step, exact reciprocal multiply
    assign unit_prod = TB_PW'(tb_reg) * TB_PW'(TB_RECIP);

    always_ff @(posedge aclk) begin
        unit_reg <= unit_prod[TB_SH +: TB_W];
    end

    // handshake chain
    assign out_free = !m_valid_reg || m_ready;
    assign p2_move  = p2_valid_reg && out_free;
    assign p2_free  = !p2_valid_reg || p2_move;
    assign p1_move  = p1_valid_reg && p2_free;
    assign s_ready  = !p1_valid_reg || p2_free;
    assign s_accept = s_valid && s_ready;

    // crossing search
    assign idx_full   = (idx_reg == DEPTH_C);
    assign cross_idx  = idx_reg - IW'(1);
    assign cross_ext  = DW'(cross_idx);
    assign cross_dist = (cross_ext > MID_C) ? (cross_ext - MID_C) : (MID_C - cross_ext);
    assign cross_hit  = !idx_full && (idx_reg != '0) && (prev_reg < level_reg)
                        && (s_sample > level_reg) && (cross_idx != '0);

    always_comb begin
        best_next = best_reg;
        dist_next = dist_reg;
        if (cross_hit && ((best_reg == '0) || (cross_dist <= dist_reg))) begin
            best_next = cross_idx;
            dist_next = cross_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            idx_reg  <= '0;
            best_reg <= '0;
            dist_reg <= '0;
        end else if (s_accept) begin
            if (s_last) begin
                prev_reg <= '0;
                idx_reg  <= '0;
                best_reg <= '0;
                dist_reg <= '0;
            end else if (!idx_full) begin
                prev_reg <= s_sample;
                idx_reg  <= idx_reg + IW'(1);
                best_reg <= best_next;
                dist_reg <= dist_next;
            end
        end
    end

    // stage 1: window placement and grid division of the room
    assign t1_s  = CALC_W'(p1_t_reg);
    assign pan_s = CALC_W'(pan_reg);
    assign tp_s  = t1_s + pan_s;

    always_comb begin
        p2_clamped_next = 1'b0;
        room            = '0;
        p2_start_next   = '0;
        if (tp_s < LEFT_C) begin
            if (t1_s < LEFT_C) begin
                p2_start_next = t1_s;
            end else begin
                room            = LEFT_C - t1_s;
                p2_clamped_next = 1'b1;
            end
        end else if (tp_s > RIGHT_C) begin
            if (t1_s > RIGHT_C) begin
                p2_start_next = t1_s - WIDTH_C;
            end else begin
                room            = RIGHT_C - t1_s;
                p2_clamped_next = 1'b1;
            end
        end else begin
            p2_start_next = tp_s - LEFT_C;
        end
    end

    // divide toward zero: magnitude quotient with the sign put back
    assign room_abs  = room[CALC_W-1] ? -room : room;
    assign room_mag  = room_abs[ROOM_W-1:0];
    assign room_prod = ROOM_PW'(room_mag) * ROOM_PW'(ROOM_RECIP);
    assign quot      = room_prod[ROOM_SH +: ROOM_W];

    always_comb begin
        if (room[CALC_W-1]) begin
            p2_steps_next = -signed'({1'b0, quot});
        end else begin
            p2_steps_next = signed'({1'b0, quot});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept && s_last) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_last) begin
            p1_t_reg <= best_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p1_move) begin
            p2_valid_reg <= 1'b1;
        end else if (p2_move) begin
            p2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            p2_t_reg       <= p1_t_reg;
            p2_clamped_reg <= p2_clamped_next;
            p2_steps_reg   <= p2_steps_next;
            p2_start_reg   <= p2_start_next;
        end
    end

    // stage 2: clamped pan, time position and saturation
    assign t2_s     = CALC_W'(p2_t_reg);
    assign adj_full = CALC_W'(p2_steps_reg) * GRID_C;

    always_comb begin
        if (adj_full > PAN_MAX) begin
            adj_sat = PAN_MAX;
        end else if (adj_full < PAN_MIN) begin
            adj_sat = PAN_MIN;
        end else begin
            adj_sat = adj_full;
        end
    end

    assign start_sel = p2_clamped_reg ? (t2_s + adj_sat - LEFT_C) : p2_start_reg;

    always_comb begin
        if (start_sel > ST_MAX) begin
            start_sat = ST_MAX;
        end else if (start_sel < ST_MIN) begin
            start_sat = ST_MIN;
        end else begin
            start_sat = start_sel;
        end
    end

    assign tpos_full = signed'(TP_W'(unit_reg)) * TP_W'(p2_steps_reg);

    always_comb begin
        if (tpos_full > TP_MAX) begin
            tpos_sat = TP_MAX;
        end else if (tpos_full < TP_MIN) begin
            tpos_sat = TP_MIN;
        end else begin
            tpos_sat = tpos_full;
        end
    end

    assign m_adj_next  = p2_clamped_reg ? adj_sat[PAN_W-1:0] : pan_reg;
    assign m_tpos_next = p2_clamped_reg ? tpos_sat[TPOS_W-1:0] : '0;
    assign t2_wide     = 32'(p2_t_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p2_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_move) begin
            m_pos_reg     <= t2_wide[POS_W-1:0];
            m_found_reg   <= (p2_t_reg != '0);
            m_start_reg   <= start_sat[START_W-1:0];
            m_adj_reg     <= m_adj_next;
            m_tpos_reg    <= m_tpos_next;
            m_clamped_reg <= p2_clamped_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_trigger_position = m_pos_reg;
    assign m_trigger_found    = m_found_reg;
    assign m_window_start     = m_start_reg;
    assign m_adjusted_pan     = m_adj_reg;
    assign m_time_position    = m_tpos_reg;
    assign m_pan_clamped      = m_clamped_reg;

endmodule
